// ===== design/lla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lla_pkg;

  // Default half side of the grid (cells per quadrant side)
  localparam int unsigned QUAD_SIDE_DEF = 32;

  // Field and register widths
  localparam int unsigned RULE_W    = 18;
  localparam int unsigned SCOPE_W   = 6;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NBR_N     = 8;
  localparam int unsigned CNT_W     = 4;

  // Survival half of the rule word starts here
  localparam int unsigned SURVIVE_SHIFT = 9;

  // Reset values of the configuration registers
  localparam logic [RULE_W-1:0]  RULE_RESET  = RULE_W'(6152);
  localparam logic [SCOPE_W-1:0] SCOPE_RESET = SCOPE_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_STEP   = 3'd0,
    OP_READ   = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_FILL   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE  = 3'd0,
    CFG_NEG_X = 3'd1,
    CFG_POS_X = 3'd2,
    CFG_NEG_Y = 3'd3,
    CFG_POS_Y = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_PRIME0,
    ST_PRIME1,
    ST_PRIME2,
    ST_STEP_CELL,
    ST_STEP_ROW,
    ST_STEP_FETCH
  } state_e;

endpackage

`default_nettype wire

// ===== design/lla_grid_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lla_grid_mem #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [$clog2(ROWS)-1:0] waddr_i,
  input  wire logic [COLS-1:0]         wdata_i,
  input  wire logic                    re_i,
  input  wire logic [$clog2(ROWS)-1:0] raddr_i,
  output logic      [COLS-1:0]         rdata_o
);

  logic [COLS-1:0] mem_q [ROWS];
  logic [COLS-1:0] rdata_q;

  // Write one row, read one row with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/lla_cell_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lla_cell_unit
  import lla_pkg::*;
(
  input  wire logic [NBR_N-1:0]  nbr_i,
  input  wire logic              alive_i,
  input  wire logic [RULE_W-1:0] rule_i,
  output logic                   next_o
);

  logic [CNT_W-1:0]         count;
  logic [SURVIVE_SHIFT-1:0] half;

  // Count live neighbours and pick the birth or survival half of the rule
  always_comb begin
    count = CNT_W'($countones(nbr_i));
    half  = alive_i ? rule_i[RULE_W-1:SURVIVE_SHIFT] : rule_i[SURVIVE_SHIFT-1:0];
    next_o = half[count];
  end

endmodule

`default_nettype wire

// ===== design/life_like_automaton_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Read, toggle and write cell: a row read state, then a write state raising the strobe.
// Fill all: writes all G rows, G = 2*QUAD_SIDE rows (64 by default), then strobes.
// Step: handled by the single cell update unit, one cell per cycle within a row, with
// one row write and one row fetch between rows, which hold the cell flow.
// One item at a time; the receiver cannot stall, each result shows for one cycle.
// After reset a clearing pass zeroes all G rows of the grid with busy high.
module life_like_automaton_engine_unit
  import lla_pkg::*;
#(
  parameter int unsigned QUAD_SIDE = QUAD_SIDE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [RULE_W-1:0]    cfg_data_i,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [COORD_W-1:0]   cell_x_i,
  input  wire logic [COORD_W-1:0]   cell_y_i,
  input  wire logic                 cell_value_i,
  output logic                      done_o,
  output logic                      cell_state_o,
  output logic                      inside_scope_o
);

  localparam int unsigned G  = 2 * QUAD_SIDE;
  localparam int unsigned AW = $clog2(G);
  localparam int unsigned SW = (AW + 1 > COORD_W) ? AW + 1 : COORD_W;
  localparam int unsigned TW = SW + 1;

  // Configuration registers
  logic [RULE_W-1:0]  rule_q;
  logic [SCOPE_W-1:0] neg_x_q, pos_x_q, neg_y_q, pos_y_q;

  // Control state
  state_e         state_q, state_d;
  logic [AW-1:0]  r_q, r_d;
  logic [AW-1:0]  c_q, c_d;
  op_e            op_q;
  logic           owed_q;
  logic           fill_val_q;
  logic           done_q;

  // Payload
  logic           val_q;
  logic           inside_q;
  logic           cell_state_q;
  logic           inside_out_q;
  logic [G-1:0]   row_a_q, row_b_q, row_c_q, next_row_q;

  // Memory port
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [G-1:0]   mem_wdata, mem_rdata;

  // Scope bounds in grid index space
  logic [SW-1:0]  eff_nx, eff_px, eff_ny, eff_py;
  logic [SW-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic [G-1:0]   col_mask, row_mask;

  // Addressed cell of an incoming item
  logic [TW-1:0]  xs, ys;
  logic           in_x, in_y;

  // Step datapath
  logic [G+1:0]   row_mask_pad;
  logic [2:0]     rm;
  logic [G+1:0]   pad_a, pad_b, pad_c;
  logic [2:0]     nb_top, nb_mid, nb_bot;
  logic [NBR_N-1:0] nbr;
  logic           unit_next;
  logic           upd;

  // Single cell datapath
  logic           new_bit;
  logic [G-1:0]   cell_row;

  // Result
  logic           fin, fin_state, fin_inside;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q  <= RULE_RESET;
      neg_x_q <= SCOPE_RESET;
      pos_x_q <= SCOPE_RESET;
      neg_y_q <= SCOPE_RESET;
      pos_y_q <= SCOPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RULE:  rule_q  <= cfg_data_i;
        CFG_NEG_X: neg_x_q <= cfg_data_i[SCOPE_W-1:0];
        CFG_POS_X: pos_x_q <= cfg_data_i[SCOPE_W-1:0];
        CFG_NEG_Y: neg_y_q <= cfg_data_i[SCOPE_W-1:0];
        CFG_POS_Y: pos_y_q <= cfg_data_i[SCOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate scope to the quadrant side and form index bounds
  always_comb begin
    eff_nx = (SW'(neg_x_q) > SW'(QUAD_SIDE)) ? SW'(QUAD_SIDE) : SW'(neg_x_q);
    eff_px = (SW'(pos_x_q) > SW'(QUAD_SIDE)) ? SW'(QUAD_SIDE) : SW'(pos_x_q);
    eff_ny = (SW'(neg_y_q) > SW'(QUAD_SIDE)) ? SW'(QUAD_SIDE) : SW'(neg_y_q);
    eff_py = (SW'(pos_y_q) > SW'(QUAD_SIDE)) ? SW'(QUAD_SIDE) : SW'(pos_y_q);
    lo_x   = SW'(QUAD_SIDE) - eff_nx;
    hi_x   = SW'(QUAD_SIDE) + eff_px;
    lo_y   = SW'(QUAD_SIDE) - eff_ny;
    hi_y   = SW'(QUAD_SIDE) + eff_py;
  end

  // Per column and per row scope masks
  for (genvar i = 0; i < G; i++) begin : g_mask
    assign col_mask[i] = (SW'(i) >= lo_x) && (SW'(i) < hi_x);
    assign row_mask[i] = (SW'(i) >= lo_y) && (SW'(i) < hi_y);
  end

  // Map signed coordinates into grid indices
  always_comb begin
    xs   = {{(TW-COORD_W){cell_x_i[COORD_W-1]}}, cell_x_i} + TW'(QUAD_SIDE);
    ys   = {{(TW-COORD_W){cell_y_i[COORD_W-1]}}, cell_y_i} + TW'(QUAD_SIDE);
    in_x = !xs[TW-1] && (xs[SW-1:0] >= lo_x) && (xs[SW-1:0] < hi_x);
    in_y = !ys[TW-1] && (ys[SW-1:0] >= lo_y) && (ys[SW-1:0] < hi_y);
  end

  // Gather the masked 3x3 neighbourhood of the current cell
  always_comb begin
    row_mask_pad = {1'b0, row_mask, 1'b0};
    rm           = row_mask_pad[r_q +: 3];
    pad_a        = {1'b0, row_a_q & col_mask, 1'b0} & {(G+2){rm[0]}};
    pad_b        = {1'b0, row_b_q & col_mask, 1'b0} & {(G+2){rm[1]}};
    pad_c        = {1'b0, row_c_q & col_mask, 1'b0} & {(G+2){rm[2]}};
    nb_top       = pad_a[c_q +: 3];
    nb_mid       = pad_b[c_q +: 3];
    nb_bot       = pad_c[c_q +: 3];
    nbr          = {nb_top, nb_mid[2], nb_mid[0], nb_bot};
    upd          = rm[1] && col_mask[c_q];
  end

  lla_cell_unit u_cell_unit (
    .nbr_i   (nbr),
    .alive_i (row_b_q[c_q]),
    .rule_i  (rule_q),
    .next_o  (unit_next)
  );

  // Modify one cell of the fetched row
  always_comb begin
    unique case (op_q)
      OP_TOGGLE: new_bit = ~mem_rdata[c_q];
      OP_WRITE:  new_bit = val_q;
      default:   new_bit = mem_rdata[c_q];
    endcase
    cell_row      = mem_rdata;
    cell_row[c_q] = new_bit;
  end

  lla_grid_mem #(
    .ROWS (G),
    .COLS (G)
  ) u_grid_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer: next state, counters, memory control and result
  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    mem_we     = 1'b0;
    mem_waddr  = r_q;
    mem_wdata  = next_row_q;
    mem_re     = 1'b0;
    mem_raddr  = r_q;
    fin        = 1'b0;
    fin_state  = 1'b0;
    fin_inside = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (op_e'(operation_i))
            OP_STEP: begin
              state_d = ST_PRIME0;
            end
            OP_READ, OP_TOGGLE, OP_WRITE: begin
              state_d = ST_CELL_RD;
              r_d     = ys[AW-1:0];
              c_d     = xs[AW-1:0];
            end
            OP_FILL: begin
              state_d = ST_FILL;
              r_d     = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {G{fill_val_q}};
        if (r_q == AW'(G - 1)) begin
          state_d = ST_IDLE;
          fin     = owed_q;
        end else begin
          r_d = r_q + 1'b1;
        end
      end

      ST_CELL_RD: begin
        mem_re  = 1'b1;
        state_d = ST_CELL_WR;
      end

      ST_CELL_WR: begin
        mem_we     = inside_q && (op_q != OP_READ);
        mem_wdata  = cell_row;
        fin        = 1'b1;
        fin_state  = inside_q & new_bit;
        fin_inside = inside_q;
        state_d    = ST_IDLE;
      end

      ST_PRIME0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = ST_PRIME1;
      end

      ST_PRIME1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
        state_d   = ST_PRIME2;
      end

      ST_PRIME2: begin
        r_d     = '0;
        c_d     = '0;
        state_d = ST_STEP_CELL;
      end

      ST_STEP_CELL: begin
        if (c_q == AW'(G - 1)) begin
          state_d = ST_STEP_ROW;
        end else begin
          c_d = c_q + 1'b1;
        end
      end

      ST_STEP_ROW: begin
        mem_we    = 1'b1;
        mem_re    = 1'b1;
        mem_raddr = r_q + AW'(2);
        if (r_q == AW'(G - 1)) begin
          state_d = ST_IDLE;
          fin     = 1'b1;
        end else begin
          state_d = ST_STEP_FETCH;
        end
      end

      ST_STEP_FETCH: begin
        r_d     = r_q + 1'b1;
        c_d     = '0;
        state_d = ST_STEP_CELL;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      r_q          <= '0;
      c_q          <= '0;
      op_q         <= OP_STEP;
      owed_q       <= 1'b0;
      fill_val_q   <= 1'b0;
      done_q       <= 1'b0;
      cell_state_q <= 1'b0;
      inside_out_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      r_q          <= r_d;
      c_q          <= c_d;
      done_q       <= fin;
      cell_state_q <= fin_state;
      inside_out_q <= fin_inside;
      if (state_q == ST_IDLE && start) begin
        op_q       <= op_e'(operation_i);
        owed_q     <= 1'b1;
        fill_val_q <= cell_value_i;
      end
    end
  end

  // Hold the item payload and the row window
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      val_q    <= cell_value_i;
      inside_q <= in_x && in_y;
    end
    unique case (state_q)
      ST_PRIME1: begin
        row_a_q <= '0;
        row_b_q <= mem_rdata;
      end
      ST_PRIME2: begin
        row_c_q <= mem_rdata;
      end
      ST_STEP_CELL: begin
        next_row_q[c_q] <= upd ? unit_next : row_b_q[c_q];
      end
      ST_STEP_ROW: begin
        row_a_q <= row_b_q;
        row_b_q <= row_c_q;
      end
      ST_STEP_FETCH: begin
        row_c_q <= (r_q < AW'(G - 2)) ? mem_rdata : '0;
      end
      default: ;
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign cell_state_o   = cell_state_q;
  assign inside_scope_o = inside_out_q;

endmodule

`default_nettype wire
